// ----- hdl/lmss_pkg.sv -----
package lmss_pkg;

  // Sizes of the stack table and the node pool.
  localparam int NUM_STACKS = 1024;
  localparam int POOL_NODES = 4096;

  localparam int STK_AW  = $clog2(NUM_STACKS);
  localparam int NODE_AW = $clog2(POOL_NODES);
  localparam int CNT_W   = $clog2(POOL_NODES + 1);

  // Fixed field widths of the command and result ports.
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // One entry of the stack table.
  typedef struct packed {
    logic [NODE_AW-1:0] bottom;
    logic [NODE_AW-1:0] top;
    logic [CNT_W-1:0]   count;
  } stk_ent_t;

  // One node of the pool.
  typedef struct packed {
    logic [NODE_AW-1:0] below;
    logic [VAL_W-1:0]   data;
  } node_ent_t;

  // Access requests from the controller to the two memories.
  typedef struct packed {
    logic              we;
    logic [STK_AW-1:0] addr;
    stk_ent_t          wdata;
  } stk_req_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] addr;
    node_ent_t          wdata;
  } node_req_t;

endpackage

// ----- hdl/lmss_ram.sv -----
module lmss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lmss_ctrl.sv -----
module lmss_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lmss_pkg::OP_W-1:0]     operation_i,
  input  logic [lmss_pkg::IDX_W-1:0]    stack_a_i,
  input  logic [lmss_pkg::IDX_W-1:0]    stack_b_i,
  input  logic signed [lmss_pkg::VAL_W-1:0] push_value_i,
  output lmss_pkg::stk_req_t            stk_req_o,
  input  lmss_pkg::stk_ent_t            stk_rdata_i,
  output lmss_pkg::node_req_t           node_req_o,
  input  lmss_pkg::node_ent_t           node_rdata_i,
  output logic                          done_o,
  output logic signed [lmss_pkg::VAL_W-1:0] pop_value_o,
  output logic [lmss_pkg::ST_W-1:0]     status_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH,
    S_POP_STK,
    S_POP_NODE,
    S_MV_B,
    S_MV_A,
    S_MV_NODE,
    S_MV_CLR
  } state_e;

  state_e                         state_q, state_d;
  logic [lmss_pkg::STK_AW-1:0]    clr_q, clr_d;
  logic [lmss_pkg::CNT_W-1:0]     used_q, used_d;
  logic [lmss_pkg::STK_AW-1:0]    a_q, a_d, b_q, b_d;
  logic [lmss_pkg::VAL_W-1:0]     v_q, v_d;
  lmss_pkg::stk_ent_t             ent_q, ent_d, ent_b_q, ent_b_d;
  logic                           done_q, done_d;
  logic [lmss_pkg::VAL_W-1:0]     pop_q, pop_d;
  logic [lmss_pkg::ST_W-1:0]      st_q, st_d;
  logic                           a_ok, b_ok;
  logic [lmss_pkg::CNT_W-1:0]     cnt_dec;

  assign a_ok    = int'(stack_a_i) < lmss_pkg::NUM_STACKS;
  assign b_ok    = int'(stack_b_i) < lmss_pkg::NUM_STACKS;
  assign cnt_dec = ent_q.count - lmss_pkg::CNT_W'(1);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    used_d     = used_q;
    a_d        = a_q;
    b_d        = b_q;
    v_d        = v_q;
    ent_d      = ent_q;
    ent_b_d    = ent_b_q;
    done_d     = 1'b0;
    pop_d      = '0;
    st_d       = lmss_pkg::ST_OK;
    stk_req_o  = '0;
    node_req_o = '0;
    stk_req_o.addr = a_q;

    case (state_q)
      S_CLEAR: begin
        stk_req_o.we   = 1'b1;
        stk_req_o.addr = clr_q;
        clr_d          = clr_q + lmss_pkg::STK_AW'(1);
        if (clr_q == lmss_pkg::STK_AW'(lmss_pkg::NUM_STACKS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          a_d = lmss_pkg::STK_AW'(stack_a_i);
          b_d = lmss_pkg::STK_AW'(stack_b_i);
          v_d = push_value_i;
          stk_req_o.addr = lmss_pkg::STK_AW'(stack_a_i);
          if (operation_i == lmss_pkg::OP_PUSH && a_ok) begin
            state_d = S_PUSH;
          end else if (operation_i == lmss_pkg::OP_POP && a_ok) begin
            state_d = S_POP_STK;
          end else if (operation_i == lmss_pkg::OP_MOVE && a_ok && b_ok &&
                       stack_a_i != stack_b_i) begin
            stk_req_o.addr = lmss_pkg::STK_AW'(stack_b_i);
            state_d        = S_MV_B;
          end else begin
            done_d = 1'b1;
            st_d   = (operation_i == lmss_pkg::OP_POP) ? lmss_pkg::ST_EMPTY
                                                       : lmss_pkg::ST_OK;
          end
        end
      end
      S_PUSH: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (used_q == lmss_pkg::CNT_W'(lmss_pkg::POOL_NODES)) begin
          st_d = lmss_pkg::ST_FULL;
        end else begin
          node_req_o.we         = 1'b1;
          node_req_o.addr       = lmss_pkg::NODE_AW'(used_q);
          node_req_o.wdata.data = v_q;
          node_req_o.wdata.below = (stk_rdata_i.count == '0) ? '0 : stk_rdata_i.top;
          stk_req_o.we           = 1'b1;
          stk_req_o.wdata.bottom = (stk_rdata_i.count == '0) ? lmss_pkg::NODE_AW'(used_q)
                                                             : stk_rdata_i.bottom;
          stk_req_o.wdata.top    = lmss_pkg::NODE_AW'(used_q);
          stk_req_o.wdata.count  = stk_rdata_i.count + lmss_pkg::CNT_W'(1);
          used_d                 = used_q + lmss_pkg::CNT_W'(1);
        end
      end
      S_POP_STK: begin
        ent_d           = stk_rdata_i;
        node_req_o.addr = stk_rdata_i.top;
        if (stk_rdata_i.count == '0) begin
          done_d  = 1'b1;
          st_d    = lmss_pkg::ST_EMPTY;
          state_d = S_IDLE;
        end else begin
          state_d = S_POP_NODE;
        end
      end
      S_POP_NODE: begin
        done_d                 = 1'b1;
        pop_d                  = node_rdata_i.data;
        stk_req_o.we           = 1'b1;
        stk_req_o.wdata.bottom = ent_q.bottom;
        stk_req_o.wdata.top    = (cnt_dec != '0) ? node_rdata_i.below : ent_q.top;
        stk_req_o.wdata.count  = cnt_dec;
        state_d                = S_IDLE;
      end
      S_MV_B: begin
        ent_b_d = stk_rdata_i;
        if (stk_rdata_i.count == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_MV_A;
        end
      end
      S_MV_A: begin
        ent_d           = stk_rdata_i;
        node_req_o.addr = ent_b_q.bottom;
        if (stk_rdata_i.count == '0) begin
          // Target is empty: it simply takes over the source's chain.
          stk_req_o.we    = 1'b1;
          stk_req_o.wdata = ent_b_q;
          state_d         = S_MV_CLR;
        end else begin
          state_d = S_MV_NODE;
        end
      end
      S_MV_NODE: begin
        node_req_o.we          = 1'b1;
        node_req_o.addr        = ent_b_q.bottom;
        node_req_o.wdata.below = ent_q.top;
        node_req_o.wdata.data  = node_rdata_i.data;
        stk_req_o.we           = 1'b1;
        stk_req_o.wdata.bottom = ent_q.bottom;
        stk_req_o.wdata.top    = ent_b_q.top;
        stk_req_o.wdata.count  = ent_q.count + ent_b_q.count;
        state_d                = S_MV_CLR;
      end
      S_MV_CLR: begin
        stk_req_o.we           = 1'b1;
        stk_req_o.addr         = b_q;
        stk_req_o.wdata        = ent_b_q;
        stk_req_o.wdata.count  = '0;
        done_d                 = 1'b1;
        state_d                = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      used_q  <= '0;
      done_q  <= 1'b0;
      a_q     <= '0;
      b_q     <= '0;
      v_q     <= '0;
      ent_q   <= '0;
      ent_b_q <= '0;
      pop_q   <= '0;
      st_q    <= lmss_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      used_q  <= used_d;
      done_q  <= done_d;
      a_q     <= a_d;
      b_q     <= b_d;
      v_q     <= v_d;
      ent_q   <= ent_d;
      ent_b_q <= ent_b_d;
      pop_q   <= pop_d;
      st_q    <= st_d;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign pop_value_o = pop_q;
  assign status_o    = st_q;

endmodule

// ----- hdl/linked_multi_stack_with_splice.sv -----
// Many LIFO stacks sharing one pool of nodes. A command is transferred at a
// rising edge where start is high and busy is low; exactly one result follows
// for each command, shown on pop_value_o and status_o for a single cycle while
// done_o is high. The receiver cannot stall: it must take the result in that
// cycle. Every command that is carried out reads the single-port stack
// table, whose read data is registered, and writes back what it changes.
// After reset the block sweeps all NUM_STACKS (1024) entries of the stack
// table once to clear every count, with busy high throughout the sweep.
// Nodes are never reclaimed: once POOL_NODES pushes have been accepted
// since reset, every further push returns the pool-full status.
module linked_multi_stack_with_splice (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [lmss_pkg::OP_W-1:0]         operation_i,
  input  logic [lmss_pkg::IDX_W-1:0]        stack_a_i,
  input  logic [lmss_pkg::IDX_W-1:0]        stack_b_i,
  input  logic signed [lmss_pkg::VAL_W-1:0] push_value_i,
  output logic                              done_o,
  output logic signed [lmss_pkg::VAL_W-1:0] pop_value_o,
  output logic [lmss_pkg::ST_W-1:0]         status_o
);

  // Requests from the sequencer and read data back from the two memories.
  lmss_pkg::stk_req_t  stk_req;
  lmss_pkg::stk_ent_t  stk_rdata;
  lmss_pkg::node_req_t node_req;
  lmss_pkg::node_ent_t node_rdata;

  // The sequencer walks each command through its memory accesses. Only one
  // command is in flight at a time, and every write lands before the next
  // read of the same table is issued, so no forwarding is needed.
  lmss_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .stack_a_i    (stack_a_i),
    .stack_b_i    (stack_b_i),
    .push_value_i (push_value_i),
    .stk_req_o    (stk_req),
    .stk_rdata_i  (stk_rdata),
    .node_req_o   (node_req),
    .node_rdata_i (node_rdata),
    .done_o       (done_o),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o)
  );

  // Stack table: bottom node, top node and depth of each stack. The counts
  // are cleared by the sweep after reset; the node fields are only read for
  // stacks that hold at least one node.
  lmss_ram #(
    .WIDTH ($bits(lmss_pkg::stk_ent_t)),
    .DEPTH (lmss_pkg::NUM_STACKS)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_req.we),
    .addr_i  (stk_req.addr),
    .wdata_i (stk_req.wdata),
    .rdata_o (stk_rdata)
  );

  // Node pool: each node keeps its value and the index of the node below.
  // A splice rewrites only the link of the source's bottom node, so the
  // sequencer reads that node first and writes its value back unchanged.
  lmss_ram #(
    .WIDTH ($bits(lmss_pkg::node_ent_t)),
    .DEPTH (lmss_pkg::POOL_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_req.we),
    .addr_i  (node_req.addr),
    .wdata_i (node_req.wdata),
    .rdata_o (node_rdata)
  );

endmodule
